FILE: rtl/core/enkc_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// enkc_pkg
// Shared types and constants for the expiring negative key cache: sizes,
// command and state codes, and the control bundle broadcast to the cells.
// ============================================================================
package enkc_pkg;

    // Number of cells in the row.
    localparam int DEPTH = 64;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Field widths fixed by the interface.
    localparam int KEY_W = 32;
    localparam int TIME_W = 32;
    localparam int MAXE_W = 7;
    localparam int CNT_OUT_W = 7;

    // Width for comparing the count against the entry limit.
    localparam int LIM_W = ((CNT_W > MAXE_W) ? CNT_W : MAXE_W) + 1;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [LIM_W-1:0] lim_t;

    // Configuration register indexes.
    localparam logic CFG_TTL = 1'b0;
    localparam logic CFG_MAX = 1'b1;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_REAP   = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_REAP
    } state_t;

    // Control broadcast to every cell in the row.
    typedef struct packed {
        logic               shift_all;
        logic               shift_match;
        logic               wr_en;
        idx_t               wr_idx;
        logic               kill_en;
        idx_t               kill_idx;
        logic               clr_all;
        logic [KEY_W-1:0]   probe_key;
        logic [TIME_W-1:0]  probe_now;
        logic [TIME_W-1:0]  ttl;
    } enkc_ctl_t;

endpackage

FILE: rtl/core/enkc_cell.sv
`timescale 1ns / 1ps
// ============================================================================
// enkc_cell
// One cache cell: holds a key, its stamp and a valid bit, compares the probe
// key, checks expiry, and takes its right neighbor's entry on a shift.
// ============================================================================
module enkc_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  enkc_pkg::idx_t                idx,
    input  enkc_pkg::enkc_ctl_t           ctl,
    input  logic [enkc_pkg::KEY_W-1:0]    nb_key,
    input  logic [enkc_pkg::TIME_W-1:0]   nb_stamp,
    input  logic                          match_in,
    output logic                          match_out,
    output logic [enkc_pkg::KEY_W-1:0]    key_q,
    output logic [enkc_pkg::TIME_W-1:0]   stamp_q,
    output logic                          valid_q,
    output logic                          hit,
    output logic                          expired
);

    logic [enkc_pkg::KEY_W-1:0]  key_reg;
    logic [enkc_pkg::KEY_W-1:0]  key_next;
    logic [enkc_pkg::TIME_W-1:0] stamp_reg;
    logic [enkc_pkg::TIME_W-1:0] stamp_next;
    logic                        valid_reg;
    logic                        valid_next;
    logic                        match_here;
    logic                        shift_here;
    logic                        wr_here;
    logic [enkc_pkg::TIME_W-1:0] age;

    // Compare and expiry check against the probe.
    assign match_here = valid_reg && (key_reg == ctl.probe_key);
    assign match_out  = match_in || match_here;
    assign age        = ctl.probe_now - stamp_reg;
    assign expired    = age > ctl.ttl;
    assign hit        = match_here && !expired;

    // A cell at or after the matching cell shifts on a refresh.
    assign shift_here = ctl.shift_all || (ctl.shift_match && match_out);
    assign wr_here    = ctl.wr_en && (ctl.wr_idx == idx);

    // Entry data: a tail write wins over a shift.
    always_comb
    begin
        key_next   = key_reg;
        stamp_next = stamp_reg;
        if (wr_here)
        begin
            key_next   = ctl.probe_key;
            stamp_next = ctl.probe_now;
        end
        else if (shift_here)
        begin
            key_next   = nb_key;
            stamp_next = nb_stamp;
        end
    end

    // Valid bit follows the count: cleared at the old tail or on a clear, set at a new one.
    always_comb
    begin
        valid_next = valid_reg;
        if (ctl.clr_all)
        begin
            valid_next = 1'b0;
        end
        else if (ctl.kill_en && (ctl.kill_idx == idx))
        begin
            valid_next = 1'b0;
        end
        else if (wr_here)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        stamp_reg <= stamp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign key_q   = key_reg;
    assign stamp_q = stamp_reg;
    assign valid_q = valid_reg;

endmodule

FILE: rtl/core/expiring_negative_key_cache_core.sv
`timescale 1ns / 1ps
// ============================================================================
// expiring_negative_key_cache_core
// Bounded cache of 32-bit keys with timestamps, kept in insertion order in a
// row of cells, with add, lookup, reap of expired entries and clear.
// ============================================================================
// Usage:
// An item (cmd, key, now) is taken at a rising edge where start is high and
// busy is low. Every item gives exactly one result, shown on the result
// ports for one cycle while done is high; the receiver cannot stall it.
// Configuration is written through cfg_valid/cfg_ready with cfg_index
// (0 ttl_seconds, 1 max_entries) and cfg_data; cfg_ready is always high.
// Write configuration only while busy is low and no result is pending.
// Add, lookup and clear are loaded into the item registers, run in ST_EXEC
// and show their registered result as the block returns to idle; a new
// item can be accepted in the cycle where done is high. All cells compare
// the probe key in parallel and shift toward the head together.
// Reap removes one head entry per cycle through the row while the head
// has expired, and stops when the head is live or the cache is empty.
// Reset empties the cache (all valid bits clear), sets ttl_seconds to 60
// and max_entries to 64, and needs no clearing pass.
// ============================================================================
module expiring_negative_key_cache_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        cmd,
    input  logic [enkc_pkg::KEY_W-1:0]        key,
    input  logic [enkc_pkg::TIME_W-1:0]       now,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_index,
    input  logic [31:0]                       cfg_data,
    output logic                              done,
    output logic                              hit,
    output logic                              evicted,
    output logic [enkc_pkg::KEY_W-1:0]        evicted_key,
    output logic [enkc_pkg::TIME_W-1:0]       evicted_age,
    output logic [enkc_pkg::CNT_OUT_W-1:0]    removed_count,
    output logic [enkc_pkg::CNT_OUT_W-1:0]    entry_count
);

    localparam int D = enkc_pkg::DEPTH;

    enkc_pkg::state_t                  state_reg;
    enkc_pkg::state_t                  state_next;
    enkc_pkg::cmd_t                    cmd_reg;
    logic [enkc_pkg::KEY_W-1:0]        key_reg;
    logic [enkc_pkg::TIME_W-1:0]       now_reg;
    logic [enkc_pkg::TIME_W-1:0]       ttl_reg;
    logic [enkc_pkg::MAXE_W-1:0]       maxe_reg;
    enkc_pkg::cnt_t                    held_reg;
    enkc_pkg::cnt_t                    held_next;
    enkc_pkg::cnt_t                    removed_reg;
    enkc_pkg::cnt_t                    removed_next;

    logic                              done_reg;
    logic                              done_next;
    logic                              hit_reg;
    logic                              hit_next;
    logic                              ev_reg;
    logic                              ev_next;
    logic [enkc_pkg::KEY_W-1:0]        ev_key_reg;
    logic [enkc_pkg::KEY_W-1:0]        ev_key_next;
    logic [enkc_pkg::TIME_W-1:0]       ev_age_reg;
    logic [enkc_pkg::TIME_W-1:0]       ev_age_next;
    enkc_pkg::cnt_t                    rm_out_reg;
    enkc_pkg::cnt_t                    rm_out_next;
    enkc_pkg::cnt_t                    cnt_out_reg;
    enkc_pkg::cnt_t                    cnt_out_next;

    enkc_pkg::enkc_ctl_t               ctl;
    logic [D:0]                        match_c;
    logic [enkc_pkg::KEY_W-1:0]        key_a   [0:D];
    logic [enkc_pkg::TIME_W-1:0]       stamp_a [0:D];
    logic [D-1:0]                      valid_v;
    logic [D-1:0]                      hit_v;
    logic [D-1:0]                      exp_v;

    logic                              accept;
    logic                              found;
    logic                              need_evict;
    enkc_pkg::lim_t                    limit;
    enkc_pkg::lim_t                    held_plus;
    enkc_pkg::idx_t                    tail_idx;
    enkc_pkg::idx_t                    last_idx;

    assign accept    = start && !busy;
    assign busy      = (state_reg != enkc_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;

    // Row of cells; the cell past the tail end feeds zeros.
    assign match_c[0] = 1'b0;
    assign key_a[D]   = '0;
    assign stamp_a[D] = '0;

    for (genvar i = 0; i < D; i++)
    begin : g_cell
        enkc_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .idx       (enkc_pkg::idx_t'(i)),
            .ctl       (ctl),
            .nb_key    (key_a[i+1]),
            .nb_stamp  (stamp_a[i+1]),
            .match_in  (match_c[i]),
            .match_out (match_c[i+1]),
            .key_q     (key_a[i]),
            .stamp_q   (stamp_a[i]),
            .valid_q   (valid_v[i]),
            .hit       (hit_v[i]),
            .expired   (exp_v[i])
        );
    end

    assign found = match_c[D];

    // Effective limit: zero acts as one, anything above the depth as the depth.
    always_comb
    begin
        limit = enkc_pkg::lim_t'(maxe_reg);
        if (maxe_reg == '0)
        begin
            limit = enkc_pkg::lim_t'(1);
        end
        else if (limit > enkc_pkg::lim_t'(D))
        begin
            limit = enkc_pkg::lim_t'(D);
        end
    end

    assign held_plus  = enkc_pkg::lim_t'(held_reg) + enkc_pkg::lim_t'(1);
    assign need_evict = (held_plus > limit) && (held_reg != '0);
    assign tail_idx   = enkc_pkg::idx_t'(held_reg);
    assign last_idx   = enkc_pkg::idx_t'(held_reg - enkc_pkg::cnt_t'(1));

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ttl_reg  <= 32'd60;
            maxe_reg <= 7'd64;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                enkc_pkg::CFG_TTL: ttl_reg  <= cfg_data;
                enkc_pkg::CFG_MAX: maxe_reg <= cfg_data[enkc_pkg::MAXE_W-1:0];
                default: ;
            endcase
        end
    end

    // Item registers, loaded on accept.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= enkc_pkg::cmd_t'(cmd);
            key_reg <= key;
            now_reg <= now;
        end
    end

    // State, count and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= enkc_pkg::ST_IDLE;
            held_reg    <= '0;
            removed_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            held_reg    <= held_next;
            removed_reg <= removed_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg     <= hit_next;
        ev_reg      <= ev_next;
        ev_key_reg  <= ev_key_next;
        ev_age_reg  <= ev_age_next;
        rm_out_reg  <= rm_out_next;
        cnt_out_reg <= cnt_out_next;
    end

    // Sequencer: next state, cell control and results.
    always_comb
    begin
        state_next   = state_reg;
        held_next    = held_reg;
        removed_next = removed_reg;
        done_next    = 1'b0;
        hit_next     = hit_reg;
        ev_next      = ev_reg;
        ev_key_next  = ev_key_reg;
        ev_age_next  = ev_age_reg;
        rm_out_next  = rm_out_reg;
        cnt_out_next = cnt_out_reg;

        ctl             = '0;
        ctl.probe_key   = key_reg;
        ctl.probe_now   = now_reg;
        ctl.ttl         = ttl_reg;

        case (state_reg)
            enkc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    removed_next = '0;
                    if (enkc_pkg::cmd_t'(cmd) == enkc_pkg::CMD_REAP)
                    begin
                        state_next = enkc_pkg::ST_REAP;
                    end
                    else
                    begin
                        state_next = enkc_pkg::ST_EXEC;
                    end
                end
            end

            enkc_pkg::ST_EXEC:
            begin
                state_next  = enkc_pkg::ST_IDLE;
                done_next   = 1'b1;
                hit_next    = 1'b0;
                ev_next     = 1'b0;
                ev_key_next = '0;
                ev_age_next = '0;
                rm_out_next = '0;
                case (cmd_reg)
                    enkc_pkg::CMD_ADD:
                    begin
                        ctl.wr_en = 1'b1;
                        if (found)
                        begin
                            // Refresh: close the gap and rewrite at the tail.
                            ctl.shift_match = 1'b1;
                            ctl.wr_idx      = last_idx;
                        end
                        else if (need_evict)
                        begin
                            ctl.shift_all = 1'b1;
                            ctl.wr_idx    = last_idx;
                            ev_next       = 1'b1;
                            ev_key_next   = key_a[0];
                            ev_age_next   = now_reg - stamp_a[0];
                        end
                        else
                        begin
                            ctl.wr_idx = tail_idx;
                            held_next  = held_reg + enkc_pkg::cnt_t'(1);
                        end
                    end
                    enkc_pkg::CMD_LOOKUP:
                    begin
                        hit_next = |hit_v;
                    end
                    enkc_pkg::CMD_CLEAR:
                    begin
                        ctl.clr_all = 1'b1;
                        rm_out_next = held_reg;
                        held_next   = '0;
                    end
                    default: ;
                endcase
                cnt_out_next = held_next;
            end

            enkc_pkg::ST_REAP:
            begin
                if ((held_reg != '0) && exp_v[0])
                begin
                    // Drop the head: the row moves one cell toward it.
                    ctl.shift_all = 1'b1;
                    ctl.kill_en   = 1'b1;
                    ctl.kill_idx  = last_idx;
                    held_next     = held_reg - enkc_pkg::cnt_t'(1);
                    removed_next  = removed_reg + enkc_pkg::cnt_t'(1);
                end
                else
                begin
                    state_next   = enkc_pkg::ST_IDLE;
                    done_next    = 1'b1;
                    hit_next     = 1'b0;
                    ev_next      = 1'b0;
                    ev_key_next  = '0;
                    ev_age_next  = '0;
                    rm_out_next  = removed_reg;
                    cnt_out_next = held_reg;
                end
            end

            default:
            begin
                state_next = enkc_pkg::ST_IDLE;
            end
        endcase
    end

    assign done          = done_reg;
    assign hit           = hit_reg;
    assign evicted       = ev_reg;
    assign evicted_key   = ev_key_reg;
    assign evicted_age   = ev_age_reg;
    assign removed_count = enkc_pkg::CNT_OUT_W'(rm_out_reg);
    assign entry_count   = enkc_pkg::CNT_OUT_W'(cnt_out_reg);

    // Valid bits in the row always match the held count.
    a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_v) == int'(held_reg))
        else $error("cell valid bits disagree with held count");

    // The count never passes the depth.
    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= enkc_pkg::cnt_t'(D))
        else $error("held count above depth");

    // A result appears only as the block returns to idle, for one cycle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == enkc_pkg::ST_IDLE))
        else $error("result shown while busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe longer than one cycle");

    // Reap leaves the head live or the cache empty.
    a_reap_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == enkc_pkg::ST_REAP && state_next == enkc_pkg::ST_IDLE)
            |-> (held_reg == '0 || !exp_v[0]))
        else $error("reap stopped on an expired head");

endmodule
